// ===== design/ords_pkg.sv =====
package ords_pkg;

    // Field widths of the two stream channels.
    localparam int MODE_W    = 2;
    localparam int POS_W     = 8;
    localparam int REC_W     = 64;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 80;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_GET = 2'd1,
        MODE_DEL = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_NONE = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Per-cell control of the order list: load a new slot number, or take the
    // entry of the upper neighbor.
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

// ===== design/ords_cell.sv =====
module ords_cell
    import ords_pkg::*;
#(
    parameter int SW = 6
) (
    input  logic          i_clk,
    input  t_cell_ctl     i_ctl,
    input  logic [SW-1:0] i_new,
    input  logic [SW-1:0] i_next,
    output logic [SW-1:0] o_entry
);

    logic [SW-1:0] r_entry;

    // One entry of the order list. A delete pulls the neighbor's entry down.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_new;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

// ===== design/ords_free_enc.sv =====
module ords_free_enc #(
    parameter int MAX_RECORDS = 64,
    parameter int SW          = 6
) (
    input  logic                   i_clk,
    input  logic [MAX_RECORDS-1:0] i_used,
    output logic [SW-1:0]          o_slot
);

    localparam int NG = (MAX_RECORDS + 7) / 8;
    localparam int GW = (NG > 1) ? $clog2(NG) : 1;

    logic [NG*8-1:0]   used_pad;
    logic [NG-1:0]     grp_any;
    logic [2:0]        grp_idx [NG];
    logic [NG-1:0]     r_grp_any;
    logic [2:0]        r_grp_idx [NG];
    logic [GW+2:0]     slot_wide;

    // Slots past the end of the store count as used.
    genvar b;
    generate
        for (b = 0; b < NG * 8; b++) begin : g_pad
            if (b < MAX_RECORDS) begin : g_real
                assign used_pad[b] = i_used[b];
            end else begin : g_fill
                assign used_pad[b] = 1'b1;
            end
        end
    endgenerate

    // First level: lowest free bit inside each group of eight, registered.
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            grp_any[g] = 1'b0;
            grp_idx[g] = 3'd0;
            for (int j = 7; j >= 0; j--) begin
                if (!used_pad[g*8 + j]) begin
                    grp_any[g] = 1'b1;
                    grp_idx[g] = 3'(j);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp_any <= grp_any;
        for (int g = 0; g < NG; g++) begin
            r_grp_idx[g] <= grp_idx[g];
        end
    end

    // Second level: lowest group that has a free slot.
    always_comb begin
        slot_wide = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                slot_wide = {GW'(g), r_grp_idx[g]};
            end
        end
    end

    assign o_slot = slot_wide[SW-1:0];

endmodule

// ===== design/ordered_record_slot_table.sv =====
// Channel   Dir  Width  tdata fields, lowest bit first
// s_axis    in   80     mode[1:0], position[9:2], record_in[73:10], zero fill
// m_axis    out  80     status[1:0], record_out[65:2], record_count[72:66], zero fill
//
// Each operation is accepted in the idle state, which looks up the order list
// and reads the payload memory; the execute state then executes it and loads
// the output register. The result register lets a new transaction be accepted
// while the previous result is still waiting. A waiting result stalls only
// the execute cycle of the following operation. Reset (synchronous, active
// low) empties the store; no clearing pass over the payload memory is needed.
module ordered_record_slot_table
    import ords_pkg::*;
#(
    parameter int MAX_RECORDS = 64,
    parameter int RECORD_BITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // mode, position, record_in, zero fill
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // status, record_out, record_count, zero fill
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    // Slot numbers and the record counter are sized from the store depth.
    localparam int SW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CW = $clog2(MAX_RECORDS + 1);

    t_state                 r_state, n_state;
    logic [MODE_W-1:0]      r_mode;
    logic [POS_W-1:0]       r_pos;
    logic [RECORD_BITS-1:0] r_rec;
    logic [SW-1:0]          r_pos_slot;
    logic [RECORD_BITS-1:0] r_rd_data;
    logic [CW-1:0]          r_count, n_count;
    logic [MAX_RECORDS-1:0] r_slot_used;
    logic                   r_out_valid;
    logic [M_TDATA_W-1:0]   r_out_data, n_out_data;

    logic [RECORD_BITS-1:0] mem [MAX_RECORDS];

    logic                   s_accept;
    logic                   exec_fire;
    logic                   add_ok;
    logic                   del_ok;
    logic [POS_W-1:0]       in_pos;
    logic [POS_W-1:0]       count_ext;
    logic [SW-1:0]          lookup_slot;
    logic [SW-1:0]          free_slot;
    logic [SW-1:0]          entry [MAX_RECORDS];
    t_cell_ctl              cell_ctl [MAX_RECORDS];
    t_status                n_status;
    logic [REC_W-1:0]       n_rec_out;

    assign in_pos    = s_axis_tdata[MODE_W +: POS_W];
    assign count_ext = POS_W'(r_count);

    // The order list: one cell per logical position. A delete shifts every
    // cell at or above the deleted position down by one, all on the same clock edge.
    genvar i;
    generate
        for (i = 0; i < MAX_RECORDS; i++) begin : g_cell
            logic [SW-1:0] next_entry;
            if (i + 1 < MAX_RECORDS) begin : g_mid
                assign next_entry = entry[i+1];
            end else begin : g_last
                assign next_entry = entry[i];
            end
            assign cell_ctl[i].load  = add_ok && (r_count == CW'(i));
            assign cell_ctl[i].shift = del_ok && (POS_W'(i) >= r_pos);
            ords_cell #(
                .SW (SW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (cell_ctl[i]),
                .i_new   (free_slot),
                .i_next  (next_entry),
                .o_entry (entry[i])
            );
        end
    endgenerate

    // The free-slot search runs every cycle on the used flags; as each operation
    // is accepted in the idle state, its pipeline is always current at execution.
    ords_free_enc #(
        .MAX_RECORDS (MAX_RECORDS),
        .SW          (SW)
    ) u_free_enc (
        .i_clk  (i_clk),
        .i_used (r_slot_used),
        .o_slot (free_slot)
    );

    // Each cell drives its slot number when its position is the one asked for.
    always_comb begin
        lookup_slot = '0;
        for (int k = 0; k < MAX_RECORDS; k++) begin
            lookup_slot = lookup_slot | (entry[k] & {SW{in_pos == POS_W'(k)}});
        end
    end

    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign exec_fire = (r_state == S_EXEC) && (!r_out_valid || m_axis_tready);

    // Next state, status and the cell controls of the execute cycle.
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        n_status      = STATUS_OK;
        n_rec_out     = '0;
        n_count       = r_count;
        add_ok        = 1'b0;
        del_ok        = 1'b0;

        unique case (r_mode)
            MODE_ADD: begin
                if (r_count >= CW'(MAX_RECORDS)) begin
                    n_status = STATUS_FULL;
                end else begin
                    add_ok  = exec_fire;
                    n_count = r_count + 1'b1;
                end
            end
            MODE_GET: begin
                if (r_pos >= count_ext) begin
                    n_status = STATUS_NONE;
                end else begin
                    n_rec_out = REC_W'(r_rd_data);
                end
            end
            MODE_DEL: begin
                if (r_pos < count_ext) begin
                    del_ok  = exec_fire;
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
            end
        endcase

        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_data = '0;
        n_out_data[STATUS_W-1:0]                 = n_status;
        n_out_data[STATUS_W +: REC_W]            = n_rec_out;
        n_out_data[STATUS_W + REC_W +: COUNT_W]  = COUNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control: counter, used flags and the result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_slot_used <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (exec_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (add_ok) begin
                r_slot_used[free_slot] <= 1'b1;
            end
            if (del_ok) begin
                r_slot_used[r_pos_slot] <= 1'b0;
            end
        end
    end

    // Operands of the accepted transaction and the result register.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_mode     <= s_axis_tdata[MODE_W-1:0];
            r_pos      <= in_pos;
            r_rec      <= s_axis_tdata[MODE_W + POS_W +: RECORD_BITS];
            r_pos_slot <= lookup_slot;
        end
        if (exec_fire) begin
            r_out_data <= n_out_data;
        end
    end

    // Payload memory: written by add, read at the slot behind the position.
    always_ff @(posedge i_clk) begin
        if (add_ok) begin
            mem[free_slot] <= r_rec;
        end
        if (s_accept) begin
            r_rd_data <= mem[lookup_slot];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== bench/tb_ordered_record_slot_table.sv =====
`timescale 1ns / 1ps

module tb_ordered_record_slot_table;
    import ords_pkg::*;

    // Depth of the record store at the block's default parameters.
    localparam int TABLE_DEPTH = 64;
    // The fourth mode code is not an operation; the block must ignore it.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int PHASES = 4;
    localparam int OPS_PER_PHASE = 185;
    localparam int REPORT_CAP = 40;

    // One operation as it travels on the slave channel.
    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  position;
        logic [REC_W-1:0]  payload;
    } t_table_op;

    // One reply as it should appear on the master channel.
    typedef struct {
        t_status            status;
        logic [REC_W-1:0]   payload;
        logic [COUNT_W-1:0] count;
    } t_table_reply;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // mode, position, record_in, zero fill
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // status, record_out, record_count, zero fill
    logic [M_TDATA_W-1:0] m_axis_tdata;

    ordered_record_slot_table i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow copy of the record store, updated once per accepted transaction.
    bit                slot_taken [TABLE_DEPTH];
    logic [REC_W-1:0]  slot_word [TABLE_DEPTH];
    logic [5:0]        position_map [TABLE_DEPTH];
    int                stored = 0;

    t_table_op    pending_ops [$];
    t_table_reply awaited_replies [$];
    t_table_op    on_bus;

    // Record count the stimulus generator expects once its queued operations
    // have executed; it steers positions and the fill/drain tide.
    int planned_count = 0;
    bit filling = 1'b1;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int replies_checked = 0;

    // Coverage tallies kept by the predictor.
    int adds_done = 0;
    int adds_full = 0;
    int gets_hit = 0;
    int gets_missed = 0;
    int deletes_hit = 0;
    int deletes_missed = 0;
    int spare_ops = 0;
    int times_full = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Applies one operation to the shadow store and returns the reply the
    // block must produce for it.
    function automatic t_table_reply apply_operation(t_table_op op);
        t_table_reply reply;
        int free_slot;
        int s;
        reply.status = STATUS_OK;
        reply.payload = '0;
        case (op.mode)
            MODE_ADD: begin
                // The lowest free slot wins, like a priority encoder.
                free_slot = TABLE_DEPTH;
                for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
                    if (!slot_taken[k]) free_slot = k;
                end
                if (stored >= TABLE_DEPTH || free_slot >= TABLE_DEPTH) begin
                    reply.status = STATUS_FULL;
                    adds_full++;
                end else begin
                    slot_taken[free_slot] = 1'b1;
                    slot_word[free_slot] = op.payload;
                    position_map[stored] = free_slot[5:0];
                    stored++;
                    adds_done++;
                    if (stored == TABLE_DEPTH) times_full++;
                end
            end
            MODE_GET: begin
                if (op.position >= stored) begin
                    reply.status = STATUS_NONE;
                    gets_missed++;
                end else begin
                    reply.payload = slot_word[position_map[op.position]];
                    gets_hit++;
                end
            end
            MODE_DEL: begin
                // Deleting a missing position is silently accepted.
                if (op.position < stored) begin
                    s = position_map[op.position];
                    slot_taken[s] = 1'b0;
                    stored--;
                    for (int i = op.position; i < stored; i++) begin
                        position_map[i] = position_map[i + 1];
                    end
                    deletes_hit++;
                end else begin
                    deletes_missed++;
                end
            end
            default: begin
                spare_ops++;
            end
        endcase
        reply.count = stored[COUNT_W-1:0];
        return reply;
    endfunction

    task automatic queue_op(logic [MODE_W-1:0] mode, logic [POS_W-1:0] position,
                            logic [REC_W-1:0] payload);
        t_table_op op;
        op.mode = mode;
        op.position = position;
        op.payload = payload;
        pending_ops.push_back(op);
        if (mode == MODE_ADD && planned_count < TABLE_DEPTH) planned_count++;
        if (mode == MODE_DEL && position < planned_count) planned_count--;
    endtask

    // Random operations that alternate between filling the store up to full
    // and draining it to empty, so that both ends are visited repeatedly.
    task automatic queue_random_ops(int n);
        int roll;
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  position;
        logic [REC_W-1:0]  payload;
        for (int k = 0; k < n; k++) begin
            if (planned_count == TABLE_DEPTH && $urandom_range(0, 4) == 0) filling = 1'b0;
            if (planned_count == 0 && $urandom_range(0, 4) == 0) filling = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                mode = MODE_SPARE;
            end else if (roll < 30) begin
                mode = MODE_GET;
            end else if (roll < (filling ? 40 : 85)) begin
                mode = MODE_DEL;
            end else begin
                mode = MODE_ADD;
            end
            // Mostly valid positions, sometimes anything the field can hold.
            if (planned_count > 0 && $urandom_range(0, 4) != 0) begin
                position = POS_W'($urandom_range(0, planned_count - 1));
            end else begin
                position = POS_W'($urandom_range(0, 255));
            end
            case ($urandom_range(0, 15))
                0: payload = '0;
                1: payload = '1;
                default: payload = {$urandom, $urandom};
            endcase
            queue_op(mode, position, payload);
        end
    endtask

    // Driver: records each accepted transaction in the predictor, then
    // presents the next pending operation unless the sender idles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                awaited_replies.push_back(apply_operation(on_bus));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    on_bus = pending_ops.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {{(S_TDATA_W - MODE_W - POS_W - REC_W){1'b0}},
                                     on_bus.payload, on_bus.position, on_bus.mode};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(string field, logic [REC_W-1:0] want,
                                   logic [REC_W-1:0] got);
        error_count++;
        if (error_count <= REPORT_CAP) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, field, want, got);
        end
    endtask

    // Compares one reply from the master channel with the oldest prediction.
    task automatic check_reply(logic [M_TDATA_W-1:0] word);
        t_table_reply want;
        logic [STATUS_W-1:0] got_status;
        logic [REC_W-1:0]    got_payload;
        logic [COUNT_W-1:0]  got_count;
        got_status  = word[STATUS_W-1:0];
        got_payload = word[STATUS_W +: REC_W];
        got_count   = word[STATUS_W + REC_W +: COUNT_W];
        if (awaited_replies.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_CAP) begin
                $display("%0t ns: reply with none expected, actual %0h", $time, word);
            end
        end else begin
            want = awaited_replies.pop_front();
            replies_checked++;
            if (got_status !== want.status) report_mismatch("status", want.status, got_status);
            if (got_payload !== want.payload) report_mismatch("record", want.payload, got_payload);
            if (got_count !== want.count) report_mismatch("count", want.count, got_count);
        end
    endtask

    // Monitor: checks each accepted reply and decides the next ready value.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_reply(m_axis_tdata);
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Polls on the falling edge, where the driver's and monitor's updates of
    // the rising edge have all settled.
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_ops.size() > 0 || s_axis_tvalid || awaited_replies.size() > 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty store lookups, the extremes of every field,
        // the ignored mode, deletion from the middle, the front and the end,
        // and reuse of a freed slot.
        queue_op(MODE_GET, 8'd0, '0);
        queue_op(MODE_DEL, 8'd0, '0);
        queue_op(MODE_DEL, 8'd255, '1);
        queue_op(MODE_ADD, 8'd0, '0);
        queue_op(MODE_ADD, 8'd255, '1);
        queue_op(MODE_ADD, 8'd17, 64'hA5A5_5A5A_F00F_0FF0);
        queue_op(MODE_ADD, 8'd0, 64'd1);
        queue_op(MODE_GET, 8'd0, '1);
        queue_op(MODE_GET, 8'd1, '0);
        queue_op(MODE_GET, 8'd2, '0);
        queue_op(MODE_GET, 8'd3, '0);
        queue_op(MODE_GET, 8'd4, '0);
        queue_op(MODE_GET, 8'd255, '0);
        queue_op(MODE_SPARE, 8'd255, '1);
        queue_op(MODE_DEL, 8'd1, '0);
        queue_op(MODE_GET, 8'd1, '0);
        queue_op(MODE_DEL, 8'd0, '0);
        queue_op(MODE_ADD, 8'd0, 64'h0123_4567_89AB_CDEF);
        queue_op(MODE_GET, 8'd2, '0);
        queue_op(MODE_DEL, 8'd255, '0);
        queue_op(MODE_DEL, 8'd2, '0);
        queue_op(MODE_GET, 8'd0, '0);

        // Random part in four flow-control phases: free flowing, a lazy
        // sender, a stalling receiver, and both at once.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            queue_random_ops(OPS_PER_PHASE);
            while (pending_ops.size() > 0) @(posedge i_clk);
        end

        wait_drained();
        // Give the pipeline time to show any stray reply.
        repeat (20) @(posedge i_clk);

        $display("Checked %0d replies: %0d adds, %0d refused as full, store full %0d times.",
                 replies_checked, adds_done, adds_full, times_full);
        $display("Gets %0d hit / %0d missed, deletes %0d hit / %0d missed, %0d ignored ops.",
                 gets_hit, gets_missed, deletes_hit, deletes_missed, spare_ops);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d replies still expected.", awaited_replies.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
